[rtl/mrft_pkg.sv]
// ----------------------------------------------------------------------------
// mrft_pkg
// Types and constants for the masked route first-match table.
// ----------------------------------------------------------------------------
package mrft_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_OUT_W  = 4;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] next_hop;
    logic [7:0]  route_flags;
    logic [3:0]  iface;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [31:0]           hop_out;
    logic [7:0]            flags_out;
    logic [3:0]            iface_out;
    logic [SLOT_OUT_W-1:0] entry_index;
    logic                  table_full;
  } rsp_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [7:0]  flags;
    logic [3:0]  iface;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Write request from the sequencer to the route memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

endpackage

[rtl/masked_route_first_match_table_core.sv]
// ----------------------------------------------------------------------------
// masked_route_first_match_table_core
// Route table with append and first-match masked lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid and are taken when req_stall is low.
//   Each request gives exactly one response on rsp/rsp_valid, taken when
//   rsp_stall is low. An add appends an entry in the next free slot or, with
//   the table full, reports table_full. A lookup walks the filled slots from
//   slot zero and returns the first whose masked destination equals the
//   masked query, or a miss with all fields zero.
//   An add, or a lookup on an empty table, goes from acceptance through the
//   emit state to the response register. A lookup first reads the filled
//   slots in order until a match or the end (at most TABLE_DEPTH slots for
//   a full miss), as the route memory's single read port delivers one
//   entry per cycle.
//   One request is in flight at a time; a new request is accepted while the
//   previous response still waits in the output register.
//   If the receiver stalls, the response holds and the sequencer waits with
//   the next result before taking further requests.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module masked_route_first_match_table_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mrft_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mrft_pkg::rsp_t rsp
);

  mrft_pkg::ram_wr_t              ram_wr;
  logic [mrft_pkg::IDX_W-1:0]     ram_rd_addr;
  logic [mrft_pkg::ENTRY_W-1:0]   ram_rd_bits;
  mrft_pkg::entry_t               ram_rd_data;

  assign ram_rd_data = mrft_pkg::entry_t'(ram_rd_bits);

  mrft_ram #(
    .WIDTH (mrft_pkg::ENTRY_W),
    .DEPTH (mrft_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_bits)
  );

  mrft_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .ram_wr      (ram_wr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule

[rtl/mrft_ram.sv]
// ----------------------------------------------------------------------------
// mrft_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mrft_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/mrft_seq.sv]
// ----------------------------------------------------------------------------
// mrft_seq
// Request sequencer: appends entries, scans the route memory one slot per
// cycle on lookup, and holds the result in an output register.
// ----------------------------------------------------------------------------
module mrft_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  mrft_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output mrft_pkg::rsp_t                rsp,
  output mrft_pkg::ram_wr_t             ram_wr,
  output logic [mrft_pkg::IDX_W-1:0]    ram_rd_addr,
  input  mrft_pkg::entry_t              ram_rd_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                       state, state_next;
  logic [mrft_pkg::CNT_W-1:0]   count, count_next;
  logic [mrft_pkg::IDX_W-1:0]   scan_idx, scan_idx_next;
  logic [31:0]                  query, query_next;
  mrft_pkg::rsp_t               result, result_next;
  logic                         rsp_valid_next;
  mrft_pkg::rsp_t               rsp_next;

  logic                         accept;
  logic                         out_free;
  logic [mrft_pkg::CNT_W-1:0]   scan_succ;
  logic                         match;
  logic                         table_is_full;

  assign accept        = req_valid && !req_stall;
  assign out_free      = !rsp_valid || !rsp_stall;
  assign scan_succ     = mrft_pkg::CNT_W'(scan_idx) + mrft_pkg::CNT_W'(1);
  assign match         = (query & ram_rd_data.mask) == (ram_rd_data.dest & ram_rd_data.mask);
  assign table_is_full = count == mrft_pkg::CNT_W'(mrft_pkg::TABLE_DEPTH);
  assign req_stall     = state != S_IDLE;

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    query_next    = query;
    result_next   = result;
    ram_wr.en     = 1'b0;
    ram_wr.addr   = count[mrft_pkg::IDX_W-1:0];
    ram_wr.data.dest  = req.address;
    ram_wr.data.mask  = req.mask;
    ram_wr.data.hop   = req.next_hop;
    ram_wr.data.flags = req.route_flags;
    ram_wr.data.iface = req.iface;
    ram_rd_addr   = '0;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next      = rsp;

    unique case (state)
      S_IDLE: begin
        result_next = '0;
        if (accept) begin
          if (req.func == mrft_pkg::FUNC_ADD) begin
            state_next = S_EMIT;
            if (table_is_full) begin
              result_next.table_full = 1'b1;
            end else begin
              ram_wr.en  = 1'b1;
              count_next = count + mrft_pkg::CNT_W'(1);
              result_next.entry_index =
                mrft_pkg::SLOT_OUT_W'(count[mrft_pkg::IDX_W-1:0]);
            end
          end else if (count == '0) begin
            // Lookup on an empty table is an immediate miss.
            state_next = S_EMIT;
          end else begin
            state_next    = S_SCAN;
            scan_idx_next = '0;
            query_next    = req.address;
          end
        end
      end
      S_SCAN: begin
        // Read data here belongs to scan_idx; the next slot is issued meanwhile.
        ram_rd_addr = scan_succ[mrft_pkg::IDX_W-1:0];
        if (match) begin
          state_next              = S_EMIT;
          result_next.hit         = 1'b1;
          result_next.hop_out     = ram_rd_data.hop;
          result_next.flags_out   = ram_rd_data.flags;
          result_next.iface_out   = ram_rd_data.iface;
          result_next.entry_index = mrft_pkg::SLOT_OUT_W'(scan_idx);
        end else if (scan_succ == count) begin
          state_next = S_EMIT;
        end else begin
          scan_idx_next = scan_succ[mrft_pkg::IDX_W-1:0];
        end
      end
      S_EMIT: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = result;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    query    <= query_next;
    result   <= result_next;
    rsp      <= rsp_next;
  end

endmodule
